// File: src/rda_pkg.sv
`timescale 1ns / 1ps
package rda_pkg;
   localparam int WORD_BITS_DEFAULT  = 64;
   localparam int MAX_DIGITS_DEFAULT = 64;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_MUL = 3'd1;
   localparam logic [2:0] OP_POW = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_MOD = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_MOD0 = 2'd2;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_code;
      logic       last_char;
      logic [2:0] op_code;
      logic [4:0] radix;
   } req_type;

   typedef struct packed {
      logic [7:0] digit_char;
      logic [1:0] status;
      logic       last_digit;
   } rsp_type;

   // Datapath commands from the controller.
   typedef struct packed {
      logic accum;      // fold the request character into its operand
      logic start_op;   // latch operands, clear them, set up the operation
      logic mul_step;   // one step of the add, multiply, power or divide sequence
      logic conv_start; // load the result into the digit converter
      logic conv_step;  // one bit of radix division
      logic conv_store; // write the digit, advance the count
      logic emit_next;  // step the emit pointer
   } cmd_type;

   typedef struct packed {
      logic op_done;
      logic conv_bit_done;
      logic conv_done;
      logic is_zero_div;
      logic emit_last;
   } sts_type;

   function automatic logic [4:0] char_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
      else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
      return v;
   endfunction

   function automatic logic [4:0] clamp_radix(input logic [4:0] r);
      logic [4:0] v;
      v = r;
      if (r < 5'd2) v = 5'd2;
      else if (r > 5'd16) v = 5'd16;
      return v;
   endfunction

   function automatic logic [7:0] digit_to_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) c = 8'h30 + 8'(d);
      else c = 8'h41 + 8'(d) - 8'd10;
      return c;
   endfunction
endpackage

// File: src/radix_digit_alu.sv
`timescale 1ns / 1ps
// Base-N calculator: each request carries one operand character and is taken
// whenever the block is idle. The request flagged last of the second operand
// runs the operation and blocks new requests until every result digit, or the
// divide-by-zero status, has gone out. Add sums the operands. Multiply builds
// the product one 16-bit slice per cycle; power repeats such products, up to
// two per exponent bit through the highest set bit. Divide and modulo run a
// bit-serial shift-and-subtract division. A set-up state then loads the
// conversion, and each result digit comes from bit-serial division of all
// WORD_BITS bits by the radix and is then stored; each digit is read from the
// digit store and then presented, held while the result side stalls.
module radix_digit_alu #(
   parameter int WORD_BITS  = rda_pkg::WORD_BITS_DEFAULT,
   parameter int MAX_DIGITS = rda_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rda_pkg::req_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rda_pkg::rsp_type  rsp_data
);
   import rda_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rda_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   rda_datapath #(.WORD_BITS(WORD_BITS), .MAX_DIGITS(MAX_DIGITS)) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .sts(sts),
      .rsp_data(rsp_data)
   );
endmodule

// File: src/rda_ram.sv
`timescale 1ns / 1ps
module rda_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: src/rda_datapath.sv
`timescale 1ns / 1ps
module rda_datapath #(
   parameter int WORD_BITS  = 64,
   parameter int MAX_DIGITS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  rda_pkg::req_type req,
   input  rda_pkg::cmd_type cmd,
   output rda_pkg::sts_type sts,
   output rda_pkg::rsp_type rsp_data
);
   import rda_pkg::*;

   localparam int CW = $clog2(WORD_BITS + 1);
   localparam int AW = $clog2(MAX_DIGITS);
   localparam int NW = $clog2(MAX_DIGITS + 1);
   localparam int MB = (WORD_BITS < 16) ? WORD_BITS : 16;

   logic [WORD_BITS-1:0] first_ff, first_in, second_ff, second_in;
   logic [WORD_BITS-1:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in; // divider remainder
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [2:0]           op_ff, op_in;
   logic [4:0]           rad_ff, rad_in;
   logic                 zero_ff, zero_in;
   logic                 done_ff, done_in;
   logic                 mbusy_ff, mbusy_in; // a product is being built
   logic                 sq_ff, sq_in;       // accumulator product of this bit is done
   logic                 tgt_ff, tgt_in;     // product goes to the base (square)
   logic [WORD_BITS-1:0] mc_ff, mc_in, mp_ff, mp_in, pr_ff, pr_in;
   logic [WORD_BITS-1:0] q_ff, q_in;    // digit conversion quotient
   logic [4:0]           r_ff, r_in;    // digit conversion partial remainder
   logic [CW-1:0]        bit_ff, bit_in;
   logic                 nz_ff, nz_in;  // quotient so far nonzero
   logic [NW-1:0]        n_ff, n_in;
   logic [NW-1:0]        k_ff, k_in;

   logic [4:0]           dval;
   logic [4:0]           rad_req;
   logic [WORD_BITS-1:0] rad_w;
   logic [WORD_BITS:0]   trial;
   logic [5:0]           rtrial;
   logic [WORD_BITS-1:0] pr_sum;
   logic                 mp_last;
   logic [3:0]           rd_digit;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;

   assign dval    = char_value(req.char_code);
   assign rad_req = clamp_radix(req.radix);
   assign rad_w   = WORD_BITS'(rad_req);
   assign trial   = {rem_ff, a_ff[WORD_BITS-1]} - {1'b0, b_ff};
   assign rtrial  = {r_ff, q_ff[WORD_BITS-1]} - {1'b0, rad_ff};

   // Products are built one 16-bit slice of the multiplier per cycle, wrapping at
   // WORD_BITS; the multiplicand moves left as the multiplier moves right.
   assign pr_sum  = pr_ff + mc_ff * WORD_BITS'(mp_ff[MB-1:0]);
   assign mp_last = ((mp_ff >> MB) == '0);

   always_comb begin
      first_in = first_ff; second_in = second_ff;
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; op_in = op_ff; rad_in = rad_ff; zero_in = zero_ff;
      done_in = done_ff; mbusy_in = mbusy_ff; sq_in = sq_ff; tgt_in = tgt_ff;
      mc_in = mc_ff; mp_in = mp_ff; pr_in = pr_ff;
      q_in = q_ff; r_in = r_ff; bit_in = bit_ff; nz_in = nz_ff;
      n_in = n_ff; k_in = k_ff;
      wr_en = 1'b0;
      if (cmd.accum && dval != 5'd16) begin
         if (!req.mode) first_in = first_ff * rad_w + WORD_BITS'(dval);
         else second_in = second_ff * rad_w + WORD_BITS'(dval);
      end
      if (cmd.start_op) begin
         b_in = second_in;
         a_in = first_ff;
         first_in = '0; second_in = '0;
         op_in = req.op_code; rad_in = rad_req;
         zero_in = (b_in == '0);
         rem_in = '0; acc_in = WORD_BITS'(1);
         cnt_in = CW'(WORD_BITS);
         done_in = 1'b0; mbusy_in = 1'b0; sq_in = 1'b0; tgt_in = 1'b0;
      end
      if (cmd.mul_step) begin
         unique case (op_ff)
            OP_MUL: begin
               if (!mbusy_ff) begin
                  mbusy_in = 1'b1; pr_in = '0; mc_in = a_ff; mp_in = b_ff;
               end else begin
                  pr_in = pr_sum; mc_in = mc_ff << MB; mp_in = mp_ff >> MB;
                  if (mp_last) begin
                     mbusy_in = 1'b0; acc_in = pr_sum; done_in = 1'b1;
                  end
               end
            end
            OP_POW: begin
               // Per exponent bit: multiply the accumulator when the bit is set,
               // then square the base and shift the exponent.
               if (!mbusy_ff) begin
                  if (b_ff == '0) done_in = 1'b1;
                  else begin
                     mbusy_in = 1'b1; pr_in = '0; mp_in = a_ff;
                     if (b_ff[0] && !sq_ff) begin
                        mc_in = acc_ff; tgt_in = 1'b0;
                     end else begin
                        mc_in = a_ff; tgt_in = 1'b1;
                     end
                  end
               end else begin
                  pr_in = pr_sum; mc_in = mc_ff << MB; mp_in = mp_ff >> MB;
                  if (mp_last) begin
                     mbusy_in = 1'b0;
                     if (tgt_ff) begin
                        a_in = pr_sum; b_in = b_ff >> 1; sq_in = 1'b0;
                     end else begin
                        acc_in = pr_sum; sq_in = 1'b1;
                     end
                  end
               end
            end
            OP_DIV, OP_MOD: begin
               cnt_in = cnt_ff - CW'(1);
               if (!trial[WORD_BITS]) rem_in = trial[WORD_BITS-1:0];
               else rem_in = {rem_ff[WORD_BITS-2:0], a_ff[WORD_BITS-1]};
               a_in = {a_ff[WORD_BITS-2:0], ~trial[WORD_BITS]};
               if (cnt_ff == CW'(1)) done_in = 1'b1;
            end
            default: begin
               acc_in = a_ff + b_ff;
               done_in = 1'b1;
            end
         endcase
      end
      if (cmd.conv_start) begin
         unique case (op_ff)
            OP_MUL, OP_POW: q_in = acc_ff;
            OP_DIV: q_in = a_ff;
            OP_MOD: q_in = rem_ff;
            default: q_in = acc_ff;
         endcase
         n_in = '0; r_in = '0; nz_in = 1'b0; bit_in = CW'(WORD_BITS);
      end
      if (cmd.conv_step) begin
         bit_in = bit_ff - CW'(1);
         if (!rtrial[5]) begin
            r_in = rtrial[4:0];
            nz_in = 1'b1;
         end else r_in = {r_ff[3:0], q_ff[WORD_BITS-1]};
         q_in = {q_ff[WORD_BITS-2:0], ~rtrial[5]};
      end
      if (cmd.conv_store) begin
         wr_en = 1'b1;
         n_in = n_ff + NW'(1);
         r_in = '0; nz_in = 1'b0; bit_in = CW'(WORD_BITS);
         k_in = n_ff + NW'(1);
      end
      if (cmd.emit_next) k_in = k_ff - NW'(1);
   end

   // k counts the digits still to send; the most significant one sits at k-1.
   assign wr_addr = n_ff[AW-1:0];
   assign rd_addr = AW'(k_ff - NW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0; second_ff <= '0;
         a_ff <= '0; b_ff <= '0; acc_ff <= '0; rem_ff <= '0;
         cnt_ff <= '0; op_ff <= '0; rad_ff <= '0; zero_ff <= 1'b0;
         done_ff <= 1'b0; mbusy_ff <= 1'b0; sq_ff <= 1'b0; tgt_ff <= 1'b0;
         mc_ff <= '0; mp_ff <= '0; pr_ff <= '0;
         q_ff <= '0; r_ff <= '0; bit_ff <= '0; nz_ff <= 1'b0;
         n_ff <= '0; k_ff <= '0;
      end else begin
         first_ff <= first_in; second_ff <= second_in;
         a_ff <= a_in; b_ff <= b_in; acc_ff <= acc_in; rem_ff <= rem_in;
         cnt_ff <= cnt_in; op_ff <= op_in; rad_ff <= rad_in; zero_ff <= zero_in;
         done_ff <= done_in; mbusy_ff <= mbusy_in; sq_ff <= sq_in; tgt_ff <= tgt_in;
         mc_ff <= mc_in; mp_ff <= mp_in; pr_ff <= pr_in;
         q_ff <= q_in; r_ff <= r_in; bit_ff <= bit_in; nz_ff <= nz_in;
         n_ff <= n_in; k_ff <= k_in;
      end
   end

   rda_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(r_ff[3:0]),
      .rd_addr(rd_addr),
      .rd_data(rd_digit)
   );

   assign sts.op_done       = done_ff;
   assign sts.conv_bit_done = (bit_ff == CW'(1));
   assign sts.conv_done     = (!nz_ff) || (n_ff == NW'(MAX_DIGITS - 1));
   assign sts.is_zero_div   = zero_ff && (op_ff == OP_DIV || op_ff == OP_MOD);
   assign sts.emit_last     = (k_ff == NW'(1));

   always_comb begin
      rsp_data.digit_char = digit_to_char(rd_digit);
      rsp_data.status     = ST_OK;
      rsp_data.last_digit = (k_ff == NW'(1));
      if (sts.is_zero_div) begin
         rsp_data.digit_char = 8'h00;
         rsp_data.status = (op_ff == OP_DIV) ? ST_DIV0 : ST_MOD0;
         rsp_data.last_digit = 1'b1;
      end
   end
endmodule

// File: src/rda_ctrl.sv
`timescale 1ns / 1ps
module rda_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rda_pkg::req_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  rda_pkg::sts_type  sts,
   output rda_pkg::cmd_type  cmd
);
   import rda_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_OP     = 3'd1;
   localparam logic [2:0] S_CONV   = 3'd2;
   localparam logic [2:0] S_STOR   = 3'd3;
   localparam logic [2:0] S_LOAD   = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;
   localparam logic [2:0] S_ERR    = 3'd6;
   localparam logic [2:0] S_CSTART = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       acc_req;

   assign req_stall = (state_ff != S_IDLE);
   assign acc_req   = req_valid && !req_stall;
   assign rsp_valid = (state_ff == S_EMIT) || (state_ff == S_ERR);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (acc_req) begin
            cmd.accum = 1'b1;
            if (req_data.mode && req_data.last_char) begin
               cmd.start_op = 1'b1;
               state_in = S_OP;
            end
         end
         S_OP: begin
            if (sts.is_zero_div) state_in = S_ERR;
            else if (sts.op_done) state_in = S_CSTART;
            else cmd.mul_step = 1'b1;
         end
         S_CSTART: begin
            cmd.conv_start = 1'b1;
            state_in = S_CONV;
         end
         S_CONV: begin
            cmd.conv_step = 1'b1;
            if (sts.conv_bit_done) state_in = S_STOR;
         end
         S_STOR: begin
            cmd.conv_store = 1'b1;
            state_in = sts.conv_done ? S_LOAD : S_CONV;
         end
         S_LOAD: state_in = S_EMIT;
         S_EMIT: if (!rsp_stall) begin
            cmd.emit_next = 1'b1;
            state_in = sts.emit_last ? S_IDLE : S_LOAD;
         end
         S_ERR: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken during output");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERR) |-> sts.is_zero_div) else $error("error without zero divisor");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
endmodule
